@@ rtl/implicit_list_heap_allocator_defines.svh @@
// Assertion macros for the heap allocator.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_DEFINES_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ILHA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ILHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ILHA_ASSERT(label, clk, rst_n, prop, msg)
`define ILHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/ilha_pkg.sv @@
// Package with the shared types and constants of the heap allocator.
package ilha_pkg;
  localparam int unsigned HeaderBytes = 8;
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [16:0] request_bytes;
    logic [15:0] payload_offset;
    logic        pointer_is_null;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] result_offset;
  } rsp_t;
endpackage

@@ rtl/ilha_req_if.sv @@
// Valid-ready request channel of the heap allocator.
interface ilha_req_if;
  logic            valid;
  logic            ready;
  ilha_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/ilha_rsp_if.sv @@
// Valid-ready response channel of the heap allocator.
interface ilha_rsp_if;
  logic            valid;
  logic            ready;
  ilha_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/ilha_cfg_if.sv @@
// Valid-ready configuration write channel of the heap allocator.
interface ilha_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/implicit_list_heap_allocator.sv @@
// Top level of the first-fit heap allocator over an implicit header list.
// Allocate walks the headers in order until a free run fits the request or the heap end is met.
// Free marks its header free and merges the free headers that follow; a null free or one below
// the first header is answered straight from idle, one whose header lies at or past the heap end skips the merge.
// Reset clears heap_end and sets heap_limit to the smaller of 65536 and HEAP_BYTES; the header memory is not cleared.
// One request is handled at a time; the next is accepted once the response is taken.
`include "implicit_list_heap_allocator_defines.svh"
module implicit_list_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  ilha_req_if.sink   req_i,
  ilha_rsp_if.source rsp_o,
  ilha_cfg_if.sink   cfg_i
);
  localparam int unsigned Depth = HEAP_BYTES / ilha_pkg::HeaderBytes;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW = ($clog2(HEAP_BYTES) + 2 > 19) ? $clog2(HEAP_BYTES) + 2 : 19;

  typedef enum logic [3:0] {
    StIdle, StARead, StAWait, StAEval, StAFin, StASplit,
    StFMark, StFRead, StFWait, StFEval, StFFin, StResp
  } state_e;

  state_e state_q;
  logic [15:0] size_mem [Depth];
  logic        used_mem [Depth];
  logic [15:0] rd_size_q;
  logic        rd_used_q;

  logic [PW-1:0] end_q, pos_q, run_q, start_q, need_q, hdr_q, lim_q;
  logic [15:0]   nbytes_q;
  logic          after_q, ok_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_size;
  logic          wr_used;
  logic          wr_size_en;
  logic [PW-1:0] run_next, pos_next, start_next;
  logic          after_next;
  ilha_pkg::rsp_t rsp_q;

  function automatic logic [AW-1:0] slot_of(logic [PW-1:0] p);
    return p[AW+2:3];
  endfunction

  assign rd_addr = slot_of(pos_q);

  always_ff @(posedge clk_i) begin
    rd_size_q <= size_mem[rd_addr];
    rd_used_q <= used_mem[rd_addr];
    if (wr_en) begin
      used_mem[wr_addr] <= wr_used;
      if (wr_size_en) begin
        size_mem[wr_addr] <= wr_size;
      end
    end
  end

  always_comb begin
    wr_en = 1'b0;
    wr_size_en = 1'b1;
    wr_addr = slot_of(start_q);
    wr_size = nbytes_q;
    wr_used = 1'b1;
    case (state_q)
      StAFin: begin
        wr_en = ok_q && (start_q < PW'(HEAP_BYTES));
      end
      StASplit: begin
        wr_addr = slot_of(start_q + need_q);
        wr_size = 16'(run_q - need_q - PW'(8));
        wr_used = 1'b0;
        wr_en = (start_q + need_q) < PW'(HEAP_BYTES);
      end
      StFMark: begin
        wr_addr = slot_of(hdr_q);
        wr_used = 1'b0;
        wr_size_en = 1'b0;
        wr_en = (hdr_q < end_q) && (hdr_q < PW'(HEAP_BYTES));
      end
      StFFin: begin
        wr_addr = slot_of(hdr_q);
        wr_size = 16'(run_q - PW'(8));
        wr_used = 1'b0;
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    run_next = run_q;
    start_next = start_q;
    after_next = after_q;
    if (!rd_used_q) begin
      if (after_q) begin
        after_next = 1'b0;
        start_next = pos_q;
      end
      run_next = run_q + PW'(8) + PW'(rd_size_q);
    end else begin
      after_next = 1'b1;
      run_next = '0;
    end
    pos_next = pos_q + PW'(8) + PW'(rd_size_q);
  end

  logic [17:0] req_round;
  assign req_round = (18'(req_i.payload.request_bytes) + 18'd7) & ~18'd7;

  assign req_i.ready = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = (state_q == StResp);
  assign rsp_o.payload = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      end_q <= '0;
      lim_q <= PW'(65536 < HEAP_BYTES ? 65536 : HEAP_BYTES);
    end else begin
      if (cfg_i.valid) begin
        lim_q <= (PW'(cfg_i.data) < PW'(HEAP_BYTES)) ? PW'(cfg_i.data) : PW'(HEAP_BYTES);
      end
      case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            nbytes_q <= 16'(req_round);
            need_q <= PW'(req_round) + PW'(8);
            pos_q <= '0;
            run_q <= '0;
            start_q <= '0;
            after_q <= 1'b0;
            hdr_q <= PW'((req_i.payload.payload_offset - 16'd8) & ~16'd7);
            if (req_i.payload.command == ilha_pkg::CmdAlloc) begin
              state_q <= StARead;
            end else if (req_i.payload.pointer_is_null ||
                         req_i.payload.payload_offset < 16'd8) begin
              rsp_q <= '{granted: 1'b1, result_offset: 16'd0};
              state_q <= StResp;
            end else begin
              state_q <= StFMark;
            end
          end
        end
        StARead: begin
          if (pos_q < end_q) begin
            state_q <= StAWait;
          end else begin
            state_q <= StAEval;
            after_q <= 1'b1;
          end
        end
        StAWait: begin
          run_q <= run_next;
          start_q <= start_next;
          after_q <= after_next;
          if (run_next >= need_q) begin
            state_q <= StAEval;
          end else begin
            pos_q <= pos_next;
            state_q <= StARead;
          end
        end
        StAEval: begin
          if (after_q && run_q == '0) begin
            ok_q <= (end_q + need_q) <= lim_q;
            start_q <= pos_q;
            run_q <= '0;
          end else begin
            ok_q <= (start_q + need_q) <= lim_q;
          end
          state_q <= StAFin;
        end
        StAFin: begin
          if (ok_q) begin
            if (run_q == '0) begin
              end_q <= end_q + need_q;
            end else if (start_q + need_q > end_q) begin
              end_q <= start_q + need_q;
            end
          end
          state_q <= (ok_q && run_q >= need_q + PW'(8)) ? StASplit : StResp;
          rsp_q <= '{granted: ok_q, result_offset: ok_q ? 16'(start_q + PW'(8)) : 16'd0};
        end
        StASplit: begin
          state_q <= StResp;
        end
        StFMark: begin
          if (hdr_q >= end_q || hdr_q >= PW'(HEAP_BYTES)) begin
            rsp_q <= '{granted: 1'b1, result_offset: 16'd0};
            state_q <= StResp;
          end else begin
            pos_q <= hdr_q;
            run_q <= '0;
            state_q <= StFRead;
          end
        end
        StFRead: begin
          state_q <= (pos_q < end_q) ? StFWait : StFFin;
        end
        StFWait: begin
          state_q <= StFEval;
        end
        StFEval: begin
          if (!rd_used_q) begin
            run_q <= run_q + PW'(8) + PW'(rd_size_q);
            pos_q <= pos_next;
            state_q <= StFRead;
          end else begin
            state_q <= StFFin;
          end
        end
        StFFin: begin
          rsp_q <= '{granted: 1'b1, result_offset: 16'd0};
          state_q <= StResp;
        end
        StResp: begin
          if (rsp_o.ready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ILHA_ASSERT(a_end_in_limit, clk_i, rst_ni, end_q <= PW'(HEAP_BYTES), "heap end past storage")
  `ILHA_ASSERT_NEXT(a_resp_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready, rsp_o.valid && $stable(rsp_q), "response dropped")
  `ILHA_ASSERT(a_busy_no_accept, clk_i, rst_ni, !(req_i.ready && rsp_o.valid), "accept while response pending")
endmodule

@@ test/implicit_list_heap_allocator_tb.sv @@
// Testbench for the implicit-list heap allocator: random allocate/free traffic against a predictor.
`timescale 1ns / 1ps
module implicit_list_heap_allocator_tb;
  localparam int unsigned HeapBytes  = 65536;
  localparam int unsigned StoreDepth = HeapBytes / ilha_pkg::HeaderBytes;
  localparam int unsigned CycleLimit = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ilha_req_if req_if ();
  ilha_rsp_if rsp_if ();
  ilha_cfg_if cfg_if ();

  implicit_list_heap_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  logic [15:0] hdr_size [StoreDepth];
  logic        hdr_used [StoreDepth];
  int unsigned heap_end_q;
  int unsigned limit_q;

  ilha_pkg::req_t pending_reqs[$];
  ilha_pkg::rsp_t expected_rsps[$];
  int unsigned    live_offsets[$];

  int unsigned cycles, issued, results_seen, mismatches;
  int unsigned allocs_ok, allocs_failed, frees_sent;
  logic        req_taken;
  int unsigned hold_left;
  bit          held_once;

  function automatic int unsigned slot_of(input int unsigned pos);
    return (pos / ilha_pkg::HeaderBytes) % StoreDepth;
  endfunction

  function automatic void write_header(input int unsigned pos, input int unsigned sz,
                                       input logic used);
    if (pos < HeapBytes) begin
      hdr_size[slot_of(pos)] = sz[15:0];
      hdr_used[slot_of(pos)] = used;
    end
  endfunction

  function automatic logic alloc_block(input int unsigned req_bytes, output int unsigned off);
    int unsigned nbytes, need, lim, run, pos, run_start, sz;
    bit after_used;
    nbytes = (req_bytes + 7) & ~32'd7;
    need = nbytes + ilha_pkg::HeaderBytes;
    lim = (limit_q < HeapBytes) ? limit_q : HeapBytes;
    run = 0;
    pos = 0;
    run_start = 0;
    after_used = 1'b0;
    off = 0;
    while (pos < heap_end_q) begin
      sz = hdr_size[slot_of(pos)];
      if (!hdr_used[slot_of(pos)]) begin
        if (after_used) begin
          after_used = 1'b0;
          run_start = pos;
        end
        run += ilha_pkg::HeaderBytes + sz;
      end else begin
        after_used = 1'b1;
        run = 0;
      end
      if (run >= need) break;
      pos += ilha_pkg::HeaderBytes + sz;
    end
    if (pos >= heap_end_q && run == 0) begin
      if (heap_end_q + need > lim) return 1'b0;
      write_header(pos, nbytes, 1'b1);
      heap_end_q += need;
      off = (pos + ilha_pkg::HeaderBytes) & 16'hFFFF;
      return 1'b1;
    end
    if (run_start + need > lim) return 1'b0;
    if (run_start + need > heap_end_q) heap_end_q = run_start + need;
    write_header(run_start, nbytes, 1'b1);
    if (run >= need + ilha_pkg::HeaderBytes)
      write_header(run_start + need, run - need - ilha_pkg::HeaderBytes, 1'b0);
    off = (run_start + ilha_pkg::HeaderBytes) & 16'hFFFF;
    return 1'b1;
  endfunction

  function automatic void free_block(input int unsigned payload);
    int unsigned hdr, pos, run, sz;
    run = 0;
    if (payload < ilha_pkg::HeaderBytes) return;
    hdr = (payload - ilha_pkg::HeaderBytes) & ~32'd7;
    if (hdr >= heap_end_q || hdr >= HeapBytes) return;
    hdr_used[slot_of(hdr)] = 1'b0;
    pos = hdr;
    while (pos < heap_end_q && !hdr_used[slot_of(pos)]) begin
      sz = hdr_size[slot_of(pos)];
      run += ilha_pkg::HeaderBytes + sz;
      pos += ilha_pkg::HeaderBytes + sz;
    end
    hdr_size[slot_of(hdr)] = 16'(run - ilha_pkg::HeaderBytes);
  endfunction

  function automatic void queue_request(input ilha_pkg::req_t r);
    ilha_pkg::rsp_t exp_rsp;
    int unsigned off;
    exp_rsp.granted = 1'b1;
    exp_rsp.result_offset = '0;
    if (r.command == ilha_pkg::CmdAlloc) begin
      exp_rsp.granted = alloc_block(r.request_bytes, off);
      if (exp_rsp.granted) begin
        exp_rsp.result_offset = off[15:0];
        live_offsets.push_back(off);
        allocs_ok++;
      end else begin
        allocs_failed++;
      end
    end else begin
      frees_sent++;
      if (!r.pointer_is_null) free_block(r.payload_offset);
    end
    pending_reqs.push_back(r);
    expected_rsps.push_back(exp_rsp);
  endfunction

  function automatic void send_alloc(input int unsigned nbytes);
    ilha_pkg::req_t r;
    r.command = ilha_pkg::CmdAlloc;
    r.request_bytes = nbytes[16:0];
    r.payload_offset = 16'($urandom);
    r.pointer_is_null = 1'($urandom);
    queue_request(r);
  endfunction

  function automatic void send_free(input int unsigned payload, input logic is_null);
    ilha_pkg::req_t r;
    r.command = ilha_pkg::CmdFree;
    r.request_bytes = 17'($urandom);
    r.payload_offset = payload[15:0];
    r.pointer_is_null = is_null;
    queue_request(r);
  endfunction

  function automatic void free_live(input int unsigned idx);
    int unsigned off;
    off = live_offsets[idx];
    live_offsets.delete(idx);
    send_free(off, 1'b0);
  endfunction

  function automatic void send_noise();
    case ($urandom_range(2))
      0: send_free($urandom, 1'b1);
      1: send_free($urandom_range(7), 1'b0);
      default: begin
        if (heap_end_q + ilha_pkg::HeaderBytes <= 65535)
          send_free($urandom_range(65535, heap_end_q + ilha_pkg::HeaderBytes), 1'b0);
        else
          send_free($urandom, 1'b1);
      end
    endcase
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [16:0] value);
    drain();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    limit_q = value;
  endtask

  always @(posedge clk_i) req_taken <= rst_ni && req_if.valid && req_if.ready;

  always @(negedge clk_i) begin
    if (req_taken) begin
      void'(pending_reqs.pop_front());
      issued++;
    end
    if (!req_if.valid || req_taken) begin
      if (rst_ni && pending_reqs.size() > 0 &&
          ((issued >= 200 && issued < 350) || $urandom_range(99) >= 18)) begin
        req_if.valid <= 1'b1;
        req_if.payload <= pending_reqs[0];
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (!held_once && results_seen >= 400) begin
      held_once = 1'b1;
      hold_left = 500;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= (results_seen >= 550 && results_seen < 700) || $urandom_range(99) >= 18;
    end
  end

  always @(posedge clk_i) begin
    ilha_pkg::rsp_t exp_rsp;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("implicit_list_heap_allocator_tb: FAIL");
      $finish;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp_if.payload);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp_if.payload.granted !== exp_rsp.granted ||
            rsp_if.payload.result_offset !== exp_rsp.result_offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d: expected granted %0b offset %0d, got granted %0b offset %0d",
                     results_seen, exp_rsp.granted, exp_rsp.result_offset,
                     rsp_if.payload.granted, rsp_if.payload.result_offset);
        end
      end
    end
  end

  initial begin
    logic [16:0] limits [6];
    int unsigned r, nbytes;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (int i = 0; i < StoreDepth; i++) begin
      hdr_size[i] = '0;
      hdr_used[i] = 1'b0;
    end
    heap_end_q = 0;
    limit_q = 65536;
    limits = '{17'd64, 17'd65535, 17'd1000, 17'd4096, 17'd300, 17'd65536};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_limit(17'd65536);
    send_alloc(0);
    send_alloc(1);
    send_alloc(8);
    send_alloc(9);
    send_alloc(100);
    send_free(0, 1'b1);
    send_free(7, 1'b0);
    send_free(65535, 1'b0);
    send_alloc(65536);
    send_alloc(65535);
    free_live(1);
    send_alloc(0);
    free_live(2);
    free_live(2);
    send_alloc(40);
    send_alloc(200);
    while (live_offsets.size() > 0) free_live(0);
    send_alloc(16);
    send_alloc(65000);
    drain();
    write_limit(17'd64);
    send_alloc(48);
    send_alloc(56);
    while (live_offsets.size() > 0) free_live(0);
    send_alloc(57);

    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int i = 0; i < 155; i++) begin
        r = $urandom_range(99);
        if (live_offsets.size() > 0 && r < (live_offsets.size() > 20 ? 70 : 35)) begin
          free_live($urandom_range(live_offsets.size() - 1));
        end else if (r >= 92) begin
          send_noise();
        end else begin
          r = $urandom_range(99);
          if (r < 85) nbytes = $urandom_range(120);
          else if (r < 95) nbytes = $urandom_range(2000, 121);
          else nbytes = $urandom_range(65536);
          send_alloc(nbytes);
        end
      end
    end

    drain();
    $display("Ran %0d requests over several heap limits: %0d allocations granted, %0d refused, %0d frees.",
             issued, allocs_ok, allocs_failed, frees_sent);
    if (mismatches == 0) begin
      $display("implicit_list_heap_allocator_tb: PASS");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("implicit_list_heap_allocator_tb: FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/ilha_pkg.sv
rtl/ilha_req_if.sv
rtl/ilha_rsp_if.sv
rtl/ilha_cfg_if.sv
rtl/implicit_list_heap_allocator.sv
test/implicit_list_heap_allocator_tb.sv
